// File: hdl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types, constants and the microcode table for the rc4 stream cipher.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W      = 8;
  localparam int SBOX_DEPTH  = 256;
  localparam int KEY_MAX_DEF = 256;
  localparam int PC_W        = 4;

  // program entry points
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_INIT = 4'd1;
  localparam logic [PC_W-1:0] PC_KSA  = 4'd2;
  localparam logic [PC_W-1:0] PC_K1   = 4'd3;
  localparam logic [PC_W-1:0] PC_K2   = 4'd4;
  localparam logic [PC_W-1:0] PC_K3   = 4'd5;
  localparam logic [PC_W-1:0] PC_FIN  = 4'd6;
  localparam logic [PC_W-1:0] PC_DATA = 4'd7;
  localparam logic [PC_W-1:0] PC_D1   = 4'd8;
  localparam logic [PC_W-1:0] PC_D2   = 4'd9;
  localparam logic [PC_W-1:0] PC_D3   = 4'd10;
  localparam logic [PC_W-1:0] PC_D4   = 4'd11;
  localparam logic [PC_W-1:0] PC_D5   = 4'd12;

  typedef enum logic [2:0] {
    ADDR_I_INC,
    ADDR_I,
    ADDR_J,
    ADDR_J_SUM,
    ADDR_K,
    ADDR_T
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_RD,
    WD_A,
    WD_K
  } wdata_sel_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_DISPATCH,
    JMP_INIT_LOOP,
    JMP_K_LOOP,
    JMP_GOTO,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    addr_sel_t        addr_sel;
    logic             mem_we;
    wdata_sel_t       wd_sel;
    logic             ld_a;
    logic             ld_b;
    logic             ld_i;
    logic             ld_j;
    logic             key_add;
    logic             k_inc;
    logic             kidx_inc;
    logic             out_ld;
    logic             sched_end;
    jmp_t             jmp;
    logic [PC_W-1:0]  target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    uword_t uw;
    logic   key_wr;
    logic   sched_start;
    logic   ld_val;
  } ctl_t;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t uw;
    uw = '0;
    uw.addr_sel = ADDR_I_INC;
    uw.wd_sel   = WD_RD;
    uw.jmp      = JMP_NEXT;
    case (pc)
      PC_IDLE: begin
        uw.jmp = JMP_DISPATCH;
      end
      // box fill with identity, k wraps back to zero
      PC_INIT: begin
        uw.addr_sel = ADDR_K;
        uw.mem_we   = 1'b1;
        uw.wd_sel   = WD_K;
        uw.k_inc    = 1'b1;
        uw.jmp      = JMP_INIT_LOOP;
        uw.target   = PC_INIT;
      end
      // key schedule: read s[k] and key byte
      PC_KSA: begin
        uw.addr_sel = ADDR_K;
      end
      PC_K1: begin
        uw.ld_a     = 1'b1;
        uw.ld_j     = 1'b1;
        uw.key_add  = 1'b1;
        uw.addr_sel = ADDR_J_SUM;
      end
      PC_K2: begin
        uw.addr_sel = ADDR_K;
        uw.mem_we   = 1'b1;
        uw.wd_sel   = WD_RD;
      end
      PC_K3: begin
        uw.addr_sel = ADDR_J;
        uw.mem_we   = 1'b1;
        uw.wd_sel   = WD_A;
        uw.k_inc    = 1'b1;
        uw.kidx_inc = 1'b1;
        uw.jmp      = JMP_K_LOOP;
        uw.target   = PC_KSA;
      end
      PC_FIN: begin
        uw.sched_end = 1'b1;
        uw.jmp       = JMP_GOTO;
        uw.target    = PC_IDLE;
      end
      // generator: i advances, read s[i]
      PC_DATA: begin
        uw.ld_i     = 1'b1;
        uw.addr_sel = ADDR_I_INC;
      end
      PC_D1: begin
        uw.ld_a     = 1'b1;
        uw.ld_j     = 1'b1;
        uw.addr_sel = ADDR_J_SUM;
      end
      PC_D2: begin
        uw.ld_b     = 1'b1;
        uw.addr_sel = ADDR_I;
        uw.mem_we   = 1'b1;
        uw.wd_sel   = WD_RD;
      end
      PC_D3: begin
        uw.addr_sel = ADDR_J;
        uw.mem_we   = 1'b1;
        uw.wd_sel   = WD_A;
      end
      PC_D4: begin
        uw.addr_sel = ADDR_T;
      end
      PC_D5: begin
        uw.addr_sel = ADDR_T;
        uw.out_ld   = 1'b1;
        uw.jmp      = JMP_WAIT_OUT;
        uw.target   = PC_IDLE;
      end
      default: begin
        uw.jmp    = JMP_GOTO;
        uw.target = PC_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

// File: hdl/rc4_sequencer.sv
// ----------------------------------------------------------------------------
// rc4_sequencer
// Step counter over the microcode table, with dispatch and conditional jumps.
// ----------------------------------------------------------------------------
module rc4_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  logic          in_operation,
  input  logic          in_last,
  input  logic          k_last,
  input  logic          out_free,
  output logic          idle,
  output rc4_pkg::ctl_t ctl
);

  logic [rc4_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     sched_r, sched_nxt;
  rc4_pkg::uword_t          uw;

  assign uw   = rc4_pkg::ucode_rom(pc_r);
  assign idle = (pc_r == rc4_pkg::PC_IDLE);

  always_comb begin
    ctl             = '0;
    ctl.uw          = uw;
    ctl.ld_val      = in_accept;
    ctl.key_wr      = in_accept && !in_operation;
    ctl.sched_start = in_accept && !in_operation && in_last;
  end

  always_comb begin
    sched_nxt = sched_r;
    pc_nxt    = pc_r + rc4_pkg::PC_W'(1);
    case (uw.jmp)
      rc4_pkg::JMP_NEXT: begin
        pc_nxt = pc_r + rc4_pkg::PC_W'(1);
      end
      rc4_pkg::JMP_DISPATCH: begin
        pc_nxt = rc4_pkg::PC_IDLE;
        if (in_accept) begin
          sched_nxt = !in_operation && in_last;
          if (in_operation) begin
            pc_nxt = rc4_pkg::PC_DATA;
          end else if (in_last) begin
            pc_nxt = rc4_pkg::PC_INIT;
          end
        end
      end
      rc4_pkg::JMP_INIT_LOOP: begin
        if (!k_last) begin
          pc_nxt = uw.target;
        end else if (sched_r) begin
          pc_nxt = pc_r + rc4_pkg::PC_W'(1);
        end else begin
          pc_nxt = rc4_pkg::PC_IDLE;
        end
      end
      rc4_pkg::JMP_K_LOOP: begin
        pc_nxt = k_last ? pc_r + rc4_pkg::PC_W'(1) : uw.target;
      end
      rc4_pkg::JMP_GOTO: begin
        pc_nxt = uw.target;
      end
      rc4_pkg::JMP_WAIT_OUT: begin
        pc_nxt = out_free ? uw.target : pc_r;
      end
      default: begin
        pc_nxt = rc4_pkg::PC_IDLE;
      end
    endcase
  end

  // reset enters the identity fill with no schedule pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= rc4_pkg::PC_INIT;
      sched_r <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      sched_r <= sched_nxt;
    end
  end

endmodule

// File: hdl/rc4_datapath.sv
// ----------------------------------------------------------------------------
// rc4_datapath
// Box memory, key store, indices and operand registers.
// ----------------------------------------------------------------------------
module rc4_datapath #(
  parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rc4_pkg::ctl_t             ctl,
  input  logic [rc4_pkg::BYTE_W-1:0] in_value,
  output logic                      k_last,
  output logic [rc4_pkg::BYTE_W-1:0] out_data
);

  localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CW = $clog2(KEY_MAX + 1);
  localparam int BW = rc4_pkg::BYTE_W;

  logic [BW-1:0] sbox_mem [rc4_pkg::SBOX_DEPTH];
  logic [BW-1:0] key_mem  [KEY_MAX];

  logic [BW-1:0] i_r, j_r, k_r, a_r, b_r, val_r, rd_r, key_rd_r;
  logic [KW-1:0] kidx_r;
  logic [CW-1:0] key_count_r;

  logic [BW-1:0] j_sum, addr, wdata;
  logic          key_room;

  assign j_sum    = j_r + rd_r + (ctl.uw.key_add ? key_rd_r : BW'(0));
  assign k_last   = (k_r == {BW{1'b1}});
  assign out_data = val_r ^ rd_r;
  assign key_room = (key_count_r < CW'(KEY_MAX));

  always_comb begin
    case (ctl.uw.addr_sel)
      rc4_pkg::ADDR_I_INC: addr = i_r + BW'(1);
      rc4_pkg::ADDR_I:     addr = i_r;
      rc4_pkg::ADDR_J:     addr = j_r;
      rc4_pkg::ADDR_J_SUM: addr = j_sum;
      rc4_pkg::ADDR_K:     addr = k_r;
      rc4_pkg::ADDR_T:     addr = a_r + b_r;
      default:             addr = i_r;
    endcase
    case (ctl.uw.wd_sel)
      rc4_pkg::WD_RD: wdata = rd_r;
      rc4_pkg::WD_A:  wdata = a_r;
      rc4_pkg::WD_K:  wdata = k_r;
      default:        wdata = rd_r;
    endcase
  end

  // single port box, registered read
  always_ff @(posedge clk) begin
    if (ctl.uw.mem_we) begin
      sbox_mem[addr] <= wdata;
    end
    rd_r <= sbox_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.key_wr && key_room) begin
      key_mem[key_count_r[KW-1:0]] <= in_value;
    end
    key_rd_r <= key_mem[kidx_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_val) val_r <= in_value;
    if (ctl.uw.ld_a) a_r <= rd_r;
    if (ctl.uw.ld_b) b_r <= rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      kidx_r      <= '0;
      key_count_r <= '0;
    end else begin
      if (ctl.uw.ld_i) i_r <= i_r + BW'(1);
      if (ctl.uw.ld_j) j_r <= j_sum;
      if (ctl.uw.k_inc) k_r <= k_r + BW'(1);
      if (ctl.uw.kidx_inc) begin
        // key bytes repeat cyclically over the stored length
        if ((CW'(kidx_r) + CW'(1)) == key_count_r) begin
          kidx_r <= '0;
        end else begin
          kidx_r <= kidx_r + KW'(1);
        end
      end
      if (ctl.key_wr && key_room) key_count_r <= key_count_r + CW'(1);
      if (ctl.sched_start) begin
        j_r    <= '0;
        k_r    <= '0;
        kidx_r <= '0;
      end
      if (ctl.uw.sched_end) begin
        i_r         <= '0;
        j_r         <= '0;
        key_count_r <= '0;
      end
    end
  end

endmodule

// File: hdl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 key schedule and keystream generator run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, in_operation,       | in
//           | in_value, in_last                       |
//   result  | out_valid, out_stall, out_byte          | out
//
// - a key word is stored at the dispatch step; a data word is serialised by the two box
//   reads, two swap writes and keystream read on the single box port
// - a key word flagged last runs 256 identity writes, then the 256 schedule
//   steps, each reading s[k] and s[j] and writing both on the box port
// - after reset the box is filled with the identity, in_stall
//   stays high during that fill
// - the result register lets the next word in while a result waits; a data word
//   finishing while the result register is full and out_stall holds waits in its last step
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
  parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [rc4_pkg::BYTE_W-1:0] in_value,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte
);

  rc4_pkg::ctl_t              ctl;
  logic                       idle;
  logic                       in_accept;
  logic                       k_last;
  logic                       out_free;
  logic [rc4_pkg::BYTE_W-1:0] out_data;
  logic                       out_valid_r;
  logic [rc4_pkg::BYTE_W-1:0] out_byte_r;

  // words are taken only at the dispatch step
  assign in_stall  = !idle;
  assign in_accept = in_valid && idle;

  // result register is free when empty or being taken this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  rc4_sequencer u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_operation (in_operation),
    .in_last      (in_last),
    .k_last       (k_last),
    .out_free     (out_free),
    .idle         (idle),
    .ctl          (ctl)
  );

  rc4_datapath #(
    .KEY_MAX (KEY_MAX)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_value (in_value),
    .k_last   (k_last),
    .out_data (out_data)
  );

  // output register, data word xor keystream byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.uw.out_ld && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (ctl.uw.out_ld && out_free) begin
      out_byte_r <= out_data;
    end
  end

endmodule
